FILE: design/arm_data_processing_execute_top_defines.svh
// Assertion macros used by the execute block's top-level RTL file.
`ifndef ARM_DATA_PROCESSING_EXECUTE_TOP_DEFINES_SVH
`define ARM_DATA_PROCESSING_EXECUTE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ARM_DP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arm_dp assertion failed");
// Next-cycle implication, checked out of reset.
`define ARM_DP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arm_dp assertion failed");
`else
`define ARM_DP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ARM_DP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/arm_dp_pkg.sv
// Types, codes and constants of the data-processing execute block.
package arm_dp_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned RIDX_W  = 4;
  localparam int unsigned NREGS   = 16;
  localparam logic [RIDX_W-1:0] PC_IDX = 4'd15;
  localparam logic [XLEN-1:0] PC_AHEAD = 32'd4;

  // Input beat
  typedef struct packed {
    logic              command;
    logic [XLEN-1:0]   instruction;
    logic [RIDX_W-1:0] load_index;
    logic [XLEN-1:0]   load_value;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [RIDX_W-1:0] dest_index;
    logic [XLEN-1:0]   result_value;
    logic              writes_register;
    logic [3:0]        flags_nzcv;
    logic              exception_return;
  } out_item_t;

  typedef enum logic {
    CMD_EXEC = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
    OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
    OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
    OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
  } alu_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // Register file read addresses
  typedef struct packed {
    logic [RIDX_W-1:0] rn;
    logic [RIDX_W-1:0] rm;
    logic [RIDX_W-1:0] rs;
  } rf_rd_t;

  // Register file write port
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  // ALU outcome
  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            writes;
    logic [3:0]      flags;
    logic            exc;
  } alu_res_t;

endpackage

FILE: design/arm_dp_regfile.sv
// Register file: two mirrored 16x32 arrays with reset-valid bits and write bypass.
module arm_dp_regfile (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  rd_en,
  input  arm_dp_pkg::rf_rd_t                    rd,
  input  arm_dp_pkg::rf_wr_t                    wr,
  output logic [arm_dp_pkg::XLEN-1:0]           rn_val,
  output logic [arm_dp_pkg::XLEN-1:0]           rm_val,
  output logic [arm_dp_pkg::XLEN-1:0]           rs_val
);

  logic [arm_dp_pkg::XLEN-1:0] mem_a [arm_dp_pkg::NREGS];
  logic [arm_dp_pkg::XLEN-1:0] mem_b [arm_dp_pkg::NREGS];
  logic [arm_dp_pkg::NREGS-1:0] vld_r, vld_nxt;

  logic [arm_dp_pkg::XLEN-1:0] rn_r, rm_r, rs_r, byp_r;
  logic [2:0] hit_r, hit_nxt;
  logic [2:0] ok_r;

  // Copy A serves Rn and Rm, copy B serves Rs
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.idx] <= wr.data;
      mem_b[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rn_r <= mem_a[rd.rn];
      rm_r <= mem_a[rd.rm];
      rs_r <= mem_b[rd.rs];
    end
  end

  // Entry valid bits stand in for clearing the arrays at reset
  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // A write landing on the same edge as the read is bypassed
  always_comb begin
    hit_nxt[2] = wr.en && (wr.idx == rd.rn);
    hit_nxt[1] = wr.en && (wr.idx == rd.rm);
    hit_nxt[0] = wr.en && (wr.idx == rd.rs);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_r  <= hit_nxt;
      byp_r  <= wr.data;
      ok_r   <= {vld_r[rd.rn], vld_r[rd.rm], vld_r[rd.rs]};
    end
  end

  // Final operand select
  assign rn_val = hit_r[2] ? byp_r : (ok_r[2] ? rn_r : '0);
  assign rm_val = hit_r[1] ? byp_r : (ok_r[1] ? rm_r : '0);
  assign rs_val = hit_r[0] ? byp_r : (ok_r[0] ? rs_r : '0);

endmodule

FILE: design/arm_dp_shifter.sv
// Barrel shifter forming operand 2 and its carry out.
module arm_dp_shifter (
  input  logic [arm_dp_pkg::XLEN-1:0] insn,
  input  logic [arm_dp_pkg::XLEN-1:0] rm_val,
  input  logic [7:0]                  rs_amt,
  input  logic                        cin,
  output logic [arm_dp_pkg::XLEN-1:0] op2,
  output logic                        carry
);

  // Returns {carry, value}
  function automatic logic [32:0] shift_core(input logic [31:0] v,
                                             input arm_dp_pkg::shift_t typ,
                                             input logic [7:0] n,
                                             input logic cin_f);
    logic [32:0]        w;
    logic signed [32:0] sw;
    logic [63:0]        dv;
    logic [32:0]        res;
    res = {cin_f, v};
    w   = '0;
    sw  = '0;
    dv  = '0;
    if (n != 8'd0) begin
      case (typ)
        arm_dp_pkg::SH_LSL: begin
          if (n < 8'd32) begin
            w   = {1'b0, v} << n[4:0];
            res = w;
          end else if (n == 8'd32) begin
            res = {v[0], 32'd0};
          end else begin
            res = '0;
          end
        end
        arm_dp_pkg::SH_LSR: begin
          if (n < 8'd32) begin
            w   = {v, 1'b0} >> n[4:0];
            res = {w[0], w[32:1]};
          end else if (n == 8'd32) begin
            res = {v[31], 32'd0};
          end else begin
            res = '0;
          end
        end
        arm_dp_pkg::SH_ASR: begin
          if (n < 8'd32) begin
            sw  = $signed({v, 1'b0}) >>> n[4:0];
            res = {sw[0], sw[32:1]};
          end else begin
            res = {v[31], {32{v[31]}}};
          end
        end
        arm_dp_pkg::SH_ROR: begin
          if (n[4:0] == 5'd0) begin
            res = {v[31], v};
          end else begin
            dv  = {v, v} >> n[4:0];
            res = {dv[31], dv[31:0]};
          end
        end
        default: res = {cin_f, v};
      endcase
    end
    return res;
  endfunction

  arm_dp_pkg::shift_t typ;
  logic [4:0]  rot;
  logic [63:0] imm_dv;
  logic [4:0]  imm_n;
  logic [32:0] sh;

  assign typ = arm_dp_pkg::shift_t'(insn[6:5]);
  assign rot = {insn[11:8], 1'b0};
  assign imm_n = insn[11:7];

  always_comb begin
    imm_dv = {24'd0, insn[7:0], 24'd0, insn[7:0]} >> rot;
    sh     = '0;
    if (insn[25]) begin
      // Rotated 8-bit immediate
      if (rot == 5'd0) begin
        sh = {cin, 24'd0, insn[7:0]};
      end else begin
        sh = {imm_dv[31], imm_dv[31:0]};
      end
    end else if (insn[4]) begin
      // Shift amount from low byte of Rs
      sh = shift_core(rm_val, typ, rs_amt, cin);
    end else if (imm_n != 5'd0 || typ == arm_dp_pkg::SH_LSL) begin
      sh = shift_core(rm_val, typ, {3'd0, imm_n}, cin);
    end else if (typ == arm_dp_pkg::SH_ROR) begin
      // RRX
      sh = {rm_val[0], cin, rm_val[31:1]};
    end else begin
      // LSR and ASR by zero encode a shift of 32
      sh = shift_core(rm_val, typ, 8'd32, cin);
    end
  end

  assign op2   = sh[31:0];
  assign carry = sh[32];

endmodule

FILE: design/arm_dp_alu.sv
// ALU for the sixteen data-processing opcodes with NZCV update.
module arm_dp_alu (
  input  logic [arm_dp_pkg::XLEN-1:0] insn,
  input  logic [arm_dp_pkg::XLEN-1:0] op1,
  input  logic [arm_dp_pkg::XLEN-1:0] op2,
  input  logic                        sh_carry,
  input  logic [3:0]                  flags_in,
  output arm_dp_pkg::alu_res_t        res
);

  arm_dp_pkg::alu_op_t op;
  logic [arm_dp_pkg::RIDX_W-1:0] rd;
  logic cin, vin;
  logic [31:0] x, y, r;
  logic        ci;
  logic [32:0] sum;
  logic        add_c, add_v;
  logic        logical, writes, exc;
  logic        c, v;

  assign op  = arm_dp_pkg::alu_op_t'(insn[24:21]);
  assign rd  = insn[15:12];
  assign cin = flags_in[1];
  assign vin = flags_in[0];

  // Adder operand select
  always_comb begin
    x  = op1;
    y  = ~op2;
    ci = 1'b1;
    unique case (op)
      arm_dp_pkg::OP_RSB: begin x = op2; y = ~op1; ci = 1'b1; end
      arm_dp_pkg::OP_ADD,
      arm_dp_pkg::OP_CMN: begin x = op1; y = op2;  ci = 1'b0; end
      arm_dp_pkg::OP_ADC: begin x = op1; y = op2;  ci = cin;  end
      arm_dp_pkg::OP_SBC: begin x = op1; y = ~op2; ci = cin;  end
      arm_dp_pkg::OP_RSC: begin x = op2; y = ~op1; ci = cin;  end
      default:            begin x = op1; y = ~op2; ci = 1'b1; end
    endcase
  end

  assign sum   = {1'b0, x} + {1'b0, y} + {32'd0, ci};
  assign add_c = sum[32];
  assign add_v = (~(x[31] ^ y[31])) & (x[31] ^ sum[31]);

  // Result select
  always_comb begin
    r       = sum[31:0];
    logical = 1'b1;
    writes  = 1'b1;
    exc     = 1'b0;
    unique case (op)
      arm_dp_pkg::OP_AND: r = op1 & op2;
      arm_dp_pkg::OP_EOR: r = op1 ^ op2;
      arm_dp_pkg::OP_SUB: begin
        logical = 1'b0;
        exc     = (rd == arm_dp_pkg::PC_IDX) && (op2 <= arm_dp_pkg::PC_AHEAD);
      end
      arm_dp_pkg::OP_RSB,
      arm_dp_pkg::OP_ADD,
      arm_dp_pkg::OP_ADC,
      arm_dp_pkg::OP_SBC,
      arm_dp_pkg::OP_RSC: logical = 1'b0;
      arm_dp_pkg::OP_TST: begin r = op1 & op2; writes = 1'b0; end
      arm_dp_pkg::OP_TEQ: begin r = op1 ^ op2; writes = 1'b0; end
      arm_dp_pkg::OP_CMP,
      arm_dp_pkg::OP_CMN: begin logical = 1'b0; writes = 1'b0; end
      arm_dp_pkg::OP_ORR: r = op1 | op2;
      arm_dp_pkg::OP_MOV: begin
        r = op2;
        // Exception return form clears bit 0
        if (rd == arm_dp_pkg::PC_IDX && insn[11:0] == 12'hE) begin
          r[0] = 1'b0;
          exc  = 1'b1;
        end
      end
      arm_dp_pkg::OP_BIC: r = op1 & ~op2;
      default:            r = ~op2;
    endcase
  end

  assign c = logical ? sh_carry : add_c;
  assign v = logical ? vin : add_v;

  assign res.result = r;
  assign res.writes = writes;
  assign res.exc    = exc;
  assign res.flags  = (insn[20] && !exc) ? {r[31], (r == 32'd0), c, v} : flags_in;

endmodule

FILE: design/arm_data_processing_execute_top.sv
// Top level of the ARM data-processing execute block.
// Usage:
//   in_valid/in_ready/in_data carry one beat per command: execute a
//   data-processing instruction or load one register file entry.
//   out_valid/out_ready/out_data return exactly one result beat per input
//   beat, in order.
//   Throughput: one beat per cycle unless out_ready stalls the output;
//   operands are read at acceptance and the previous beat's register
//   write is bypassed, so dependent instructions follow back to back.
//   The single execute stage sets this rate.
//   Reset (rst_n low, synchronous) empties both stages, marks every register
//   file entry as zero and clears NZCV.
//   When out_ready is low the result register holds; one more beat may sit
//   in the execute stage, after which in_ready drops until the output drains.
module arm_data_processing_execute_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arm_dp_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output arm_dp_pkg::out_item_t out_data
);

`include "arm_data_processing_execute_top_defines.svh"

  logic exe_valid_r, exe_valid_nxt;
  arm_dp_pkg::in_item_t exe_item_r;
  logic out_valid_r, out_valid_nxt;
  arm_dp_pkg::out_item_t out_data_r, out_data_nxt;
  logic [3:0] flags_r, flags_nxt;

  logic accept, advance, is_load;
  arm_dp_pkg::rf_rd_t rf_rd;
  arm_dp_pkg::rf_wr_t rf_wr;
  logic [arm_dp_pkg::XLEN-1:0] rn_val, rm_val, rs_val, op1, op2;
  logic sh_carry;
  arm_dp_pkg::alu_res_t alu;

  // Handshake
  assign advance  = exe_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !exe_valid_r || advance;
  assign accept   = in_valid && in_ready;
  assign is_load  = (exe_item_r.command == arm_dp_pkg::CMD_LOAD);

  // Operand addresses come straight from the incoming beat
  assign rf_rd.rn = in_data.instruction[19:16];
  assign rf_rd.rm = in_data.instruction[3:0];
  assign rf_rd.rs = in_data.instruction[11:8];

  arm_dp_regfile u_rf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd     (rf_rd),
    .wr     (rf_wr),
    .rn_val (rn_val),
    .rm_val (rm_val),
    .rs_val (rs_val)
  );

  // Rn = PC reads ahead
  assign op1 = (exe_item_r.instruction[19:16] == arm_dp_pkg::PC_IDX)
             ? rn_val + arm_dp_pkg::PC_AHEAD : rn_val;

  arm_dp_shifter u_sh (
    .insn   (exe_item_r.instruction),
    .rm_val (rm_val),
    .rs_amt (rs_val[7:0]),
    .cin    (flags_r[1]),
    .op2    (op2),
    .carry  (sh_carry)
  );

  arm_dp_alu u_alu (
    .insn     (exe_item_r.instruction),
    .op1      (op1),
    .op2      (op2),
    .sh_carry (sh_carry),
    .flags_in (flags_r),
    .res      (alu)
  );

  // Register file write from the retiring beat
  always_comb begin
    rf_wr.en   = advance && (is_load || alu.writes);
    rf_wr.idx  = is_load ? exe_item_r.load_index : exe_item_r.instruction[15:12];
    rf_wr.data = is_load ? exe_item_r.load_value : alu.result;
  end

  // Next state for stages, flags and result
  always_comb begin
    exe_valid_nxt = exe_valid_r;
    out_valid_nxt = out_valid_r;
    flags_nxt     = flags_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      exe_valid_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      if (is_load) begin
        out_data_nxt.dest_index       = exe_item_r.load_index;
        out_data_nxt.result_value     = exe_item_r.load_value;
        out_data_nxt.writes_register  = 1'b0;
        out_data_nxt.flags_nzcv       = flags_r;
        out_data_nxt.exception_return = 1'b0;
      end else begin
        flags_nxt                     = alu.flags;
        out_data_nxt.dest_index       = exe_item_r.instruction[15:12];
        out_data_nxt.result_value     = alu.result;
        out_data_nxt.writes_register  = alu.writes;
        out_data_nxt.flags_nzcv       = alu.flags;
        out_data_nxt.exception_return = alu.exc;
      end
    end
    if (accept) begin
      exe_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exe_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      exe_valid_r <= exe_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      exe_item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ARM_DP_ASSERT_NEXT(a_exe_hold, clk, rst_n, exe_valid_r && !advance,
    exe_valid_r && $stable(exe_item_r))
  `ARM_DP_ASSERT_NEXT(a_flags_only_exec, clk, rst_n, !(advance && !is_load),
    $stable(flags_r))
  `ARM_DP_ASSERT_NEXT(a_exc_keeps_flags, clk, rst_n, advance && !is_load && alu.exc,
    $stable(flags_r) && out_data_r.exception_return)
  `ARM_DP_ASSERT_NEXT(a_load_result, clk, rst_n, advance && is_load,
    !out_data_r.writes_register && !out_data_r.exception_return)
  `ARM_DP_ASSERT_NOW(a_out_flags_match, clk, rst_n, out_valid_r,
    out_data_r.flags_nzcv == flags_r || exe_valid_r)

endmodule
